FILE: src/tgd_pkg.sv
// Shared types and constants for the touch gesture detector.
// Used by tgd_step and touch_gesture_detector; depends on nothing else.
package tgd_pkg;

    // Action codes carried in each result.
    localparam logic [2:0] ACT_NONE         = 3'd0;
    localparam logic [2:0] ACT_SLEEP        = 3'd1;
    localparam logic [2:0] ACT_STANDBY      = 3'd2;
    localparam logic [2:0] ACT_STOP_SLEEP   = 3'd3;
    localparam logic [2:0] ACT_STOP_STANDBY = 3'd4;
    localparam logic [2:0] ACT_START        = 3'd5;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DTAP_GAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_HOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT    = 3'd5;

    // Reset values of the configuration registers, in milliseconds.
    localparam logic [15:0] RST_DEBOUNCE   = 16'd25;
    localparam logic [15:0] RST_TAP_MIN    = 16'd60;
    localparam logic [15:0] RST_TAP_MAX    = 16'd500;
    localparam logic [15:0] RST_DTAP_GAP   = 16'd550;
    localparam logic [15:0] RST_SLEEP_HOLD = 16'd4000;
    localparam logic [15:0] RST_LOCKOUT    = 16'd250;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] tap_min_ms;
        logic [15:0] tap_max_ms;
        logic [15:0] double_tap_gap_ms;
        logic [15:0] sleep_hold_ms;
        logic [15:0] lockout_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        touch_raw;
        logic        link_connected;
        logic        stream_active;
        logic        standby_active;
        logic        update_busy;
        logic        sleep_requested;
    } item_t;

    typedef struct packed {
        logic [2:0] action;
        logic       touch_stable;
    } result_t;

    typedef struct packed {
        logic [31:0] rearm_time;
        logic        prev_connected;
        logic        prev_streaming;
        logic        prev_standby;
        logic        standby_after_stop;
        logic        sleep_after_stop;
        logic        tap_pending;
        logic [31:0] last_tap_time;
        logic [31:0] press_time;
        logic        raw_level;
        logic        stable_level;
        logic [31:0] raw_change_time;
    } state_t;

endpackage

FILE: src/tgd_step.sv
// Combinational step of the gesture detector: debounce, lockout, press
// classification, double tap pairing and deferred sleep or standby.
// Depends on tgd_pkg for the item, state, configuration and action types.
module tgd_step (
    input  tgd_pkg::cfg_t    cfg,
    input  tgd_pkg::item_t   item,
    input  tgd_pkg::state_t  state_cur,
    output tgd_pkg::state_t  state_nxt,
    output tgd_pkg::result_t result
);

    always_comb
    begin
        tgd_pkg::state_t st;
        logic [2:0]      act;
        logic [31:0]     held;
        logic            busy;
        logic            strm;
        logic            touched;

        st      = state_cur;
        act     = tgd_pkg::ACT_NONE;
        held    = '0;
        busy    = item.update_busy;
        strm    = item.stream_active;
        touched = item.touch_raw;

        if (busy || item.sleep_requested)
        begin
            st.press_time         = '0;
            st.tap_pending        = 1'b0;
            st.last_tap_time      = '0;
            st.sleep_after_stop   = 1'b0;
            st.standby_after_stop = 1'b0;
        end

        if (st.sleep_after_stop && !strm && !touched && !busy)
        begin
            st.sleep_after_stop = 1'b0;
            act = tgd_pkg::ACT_SLEEP;
        end
        else if (st.standby_after_stop && !strm && !touched && !busy)
        begin
            st.standby_after_stop = 1'b0;
            act = tgd_pkg::ACT_STANDBY;
        end
        else
        begin
            // A change of the link, stream or standby flag restarts the lockout.
            if (item.link_connected != st.prev_connected ||
                strm != st.prev_streaming ||
                item.standby_active != st.prev_standby)
            begin
                st.prev_connected = item.link_connected;
                st.prev_streaming = strm;
                st.prev_standby   = item.standby_active;
                st.rearm_time     = item.now_ms + {16'd0, cfg.lockout_ms};
                st.press_time     = '0;
                st.tap_pending    = 1'b0;
                st.last_tap_time  = '0;
            end

            if (st.tap_pending && st.last_tap_time != '0 &&
                (item.now_ms - st.last_tap_time) > {16'd0, cfg.double_tap_gap_ms})
            begin
                st.tap_pending   = 1'b0;
                st.last_tap_time = '0;
            end

            if (touched != st.raw_level)
            begin
                st.raw_level       = touched;
                st.raw_change_time = item.now_ms;
            end

            if (touched != st.stable_level &&
                (item.now_ms - st.raw_change_time) >= {16'd0, cfg.debounce_ms})
            begin
                st.stable_level = touched;
                if (touched)
                begin
                    // Bit 31 of the difference set means the lockout has not yet run out.
                    held = item.now_ms - st.rearm_time;
                    if (busy || item.sleep_requested || held[31])
                    begin
                        st.press_time    = '0;
                        st.tap_pending   = 1'b0;
                        st.last_tap_time = '0;
                    end
                    else
                    begin
                        st.press_time = item.now_ms;
                    end
                end
                else
                begin
                    held = (st.press_time != '0) ? (item.now_ms - st.press_time) : '0;
                    st.press_time = '0;
                    if (held == '0 || busy)
                    begin
                        st.tap_pending   = 1'b0;
                        st.last_tap_time = '0;
                    end
                    else if (held >= {16'd0, cfg.sleep_hold_ms})
                    begin
                        st.tap_pending   = 1'b0;
                        st.last_tap_time = '0;
                        st.rearm_time    = item.now_ms + {16'd0, cfg.lockout_ms};
                        if (strm)
                        begin
                            st.sleep_after_stop = 1'b1;
                            act = tgd_pkg::ACT_STOP_SLEEP;
                        end
                        else
                        begin
                            act = tgd_pkg::ACT_SLEEP;
                        end
                    end
                    else if (held < {16'd0, cfg.tap_min_ms} ||
                             held > {16'd0, cfg.tap_max_ms})
                    begin
                        st.tap_pending   = 1'b0;
                        st.last_tap_time = '0;
                    end
                    else if (!st.tap_pending || st.last_tap_time == '0 ||
                             (item.now_ms - st.last_tap_time) >
                             {16'd0, cfg.double_tap_gap_ms})
                    begin
                        st.tap_pending   = 1'b1;
                        st.last_tap_time = item.now_ms;
                    end
                    else
                    begin
                        st.tap_pending   = 1'b0;
                        st.last_tap_time = '0;
                        st.rearm_time    = item.now_ms + {16'd0, cfg.lockout_ms};
                        if (strm)
                        begin
                            st.standby_after_stop = 1'b1;
                            act = tgd_pkg::ACT_STOP_STANDBY;
                        end
                        else if (item.link_connected)
                        begin
                            act = tgd_pkg::ACT_START;
                        end
                    end
                end
            end
        end

        state_nxt           = st;
        result.action       = act;
        result.touch_stable = st.stable_level;
    end

endmodule

FILE: src/touch_gesture_detector.sv
// Touch gesture detector: one action code and the debounced level per poll request.
// A request is held in the input register, then its result in the result register, which
// keeps it until m_axis_tready. Throughput: one request per cycle while m_axis_tready is
// high, set by the combinational step logic between the two registers. Reset is
// asynchronous, active low: the step state and both valid flags clear to zero, and the
// configuration registers return to their default values. Depends on tgd_pkg and tgd_step.
module touch_gesture_detector (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Poll requests. tdata: now_ms[31:0], touch_raw, link_connected, stream_active,
    // standby_active, update_busy, sleep_requested, then two zero bits.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [tgd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // Results. tdata: action[2:0], touch_stable, then four zero bits.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [tgd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // Configuration writes.
    input  logic                                 cfg_we,
    input  logic [tgd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [15:0]                          cfg_data
);

    tgd_pkg::cfg_t    cfg_reg;
    tgd_pkg::item_t   in_item_reg;
    logic             in_valid_reg;
    tgd_pkg::state_t  state_reg;
    tgd_pkg::state_t  state_next;
    tgd_pkg::result_t out_result_reg;
    tgd_pkg::result_t result_next;
    logic             out_valid_reg;
    logic             advance;
    tgd_pkg::item_t   in_item;

    assign in_item.now_ms          = s_axis_tdata[31:0];
    assign in_item.touch_raw       = s_axis_tdata[32];
    assign in_item.link_connected  = s_axis_tdata[33];
    assign in_item.stream_active   = s_axis_tdata[34];
    assign in_item.standby_active  = s_axis_tdata[35];
    assign in_item.update_busy     = s_axis_tdata[36];
    assign in_item.sleep_requested = s_axis_tdata[37];

    // The held item moves on whenever the result register is free or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms       <= tgd_pkg::RST_DEBOUNCE;
            cfg_reg.tap_min_ms        <= tgd_pkg::RST_TAP_MIN;
            cfg_reg.tap_max_ms        <= tgd_pkg::RST_TAP_MAX;
            cfg_reg.double_tap_gap_ms <= tgd_pkg::RST_DTAP_GAP;
            cfg_reg.sleep_hold_ms     <= tgd_pkg::RST_SLEEP_HOLD;
            cfg_reg.lockout_ms        <= tgd_pkg::RST_LOCKOUT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tgd_pkg::CFG_DEBOUNCE:   cfg_reg.debounce_ms       <= cfg_data;
                tgd_pkg::CFG_TAP_MIN:    cfg_reg.tap_min_ms        <= cfg_data;
                tgd_pkg::CFG_TAP_MAX:    cfg_reg.tap_max_ms        <= cfg_data;
                tgd_pkg::CFG_DTAP_GAP:   cfg_reg.double_tap_gap_ms <= cfg_data;
                tgd_pkg::CFG_SLEEP_HOLD: cfg_reg.sleep_hold_ms     <= cfg_data;
                tgd_pkg::CFG_LOCKOUT:    cfg_reg.lockout_ms        <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg <= in_item;
        end
    end

    tgd_step u_step (
        .cfg       (cfg_reg),
        .item      (in_item_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_result_reg.touch_stable, out_result_reg.action};

endmodule
